>>> rtl/core/rnsr_pkg.sv
`timescale 1ns / 1ps

package rnsr_pkg;

  localparam int RESIDUE_BITS = 31;
  localparam int PROD_BITS    = 2 * RESIDUE_BITS;
  localparam int SUM_BITS     = PROD_BITS + 1;

  // remainder unit: bits of the product consumed per pipeline stage
  localparam int RED_STEPS    = 4;
  localparam int RED_STAGES   = (PROD_BITS + RED_STEPS - 1) / RED_STEPS;
  localparam int RED_BITS     = RED_STAGES * RED_STEPS;

  localparam int LANE_STAGES  = RED_STAGES + 1;
  localparam int RECON_STAGES = 4;
  localparam int PIPE_STAGES  = LANE_STAGES + RECON_STAGES;

  localparam int CFG_IDX_BITS = 3;

  typedef logic [RESIDUE_BITS-1:0] residue_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_MODULUS_A      = 3'd0,
    CFG_MODULUS_B      = 3'd1,
    CFG_CRT_INVERSE_A  = 3'd2,
    CFG_CRT_INVERSE_B  = 3'd3,
    CFG_HALF_RESIDUE_A = 3'd4,
    CFG_HALF_RESIDUE_B = 3'd5
  } cfg_idx_e;

  localparam logic [63:0] MODULUS_A_RST_FULL = 64'd2147483647;
  localparam logic [63:0] MODULUS_B_RST_FULL = 64'd2147483629;
  localparam residue_t    MODULUS_A_RST      = MODULUS_A_RST_FULL[RESIDUE_BITS-1:0];
  localparam residue_t    MODULUS_B_RST      = MODULUS_B_RST_FULL[RESIDUE_BITS-1:0];

  typedef struct packed {
    residue_t modulus_a;
    residue_t modulus_b;
    residue_t crt_inverse_a;
    residue_t crt_inverse_b;
    residue_t half_residue_a;
    residue_t half_residue_b;
  } cfg_t;

  typedef struct packed {
    residue_t rounded_a;
    residue_t rounded_b;
    logic     adjusted;
  } res_t;

  typedef enum logic [1:0] {
    BUF_EMPTY = 2'd0,
    BUF_ONE   = 2'd1,
    BUF_FULL  = 2'd2
  } buf_state_e;

endpackage

>>> rtl/core/rnsr_lane.sv
`timescale 1ns / 1ps

module rnsr_lane import rnsr_pkg::*; (
  input  logic     clk_i,
  input  logic     adv_i,
  input  residue_t residue_i,
  input  residue_t inverse_i,
  input  residue_t modulus_i,
  output residue_t residue_o,
  output residue_t crt_o
);

  // one shift-and-subtract step per product bit, RED_STEPS per stage
  function automatic residue_t rem_step(residue_t r_in, logic [RED_STEPS-1:0] bits,
                                        residue_t q);
    logic [RESIDUE_BITS:0] w;
    residue_t              r;
    r = r_in;
    for (int j = RED_STEPS - 1; j >= 0; j--) begin
      w = {r, bits[j]};
      if (w >= {1'b0, q}) begin
        w = w - {1'b0, q};
      end
      r = w[RESIDUE_BITS-1:0];
    end
    return r;
  endfunction

  logic [PROD_BITS-1:0] prod;
  logic [RED_BITS-1:0]  dvd_q [RED_STAGES];
  residue_t             rem_q [RED_STAGES];
  residue_t             res_q [LANE_STAGES];

  assign prod = PROD_BITS'(residue_i) * PROD_BITS'(inverse_i);

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      dvd_q[0] <= RED_BITS'(prod);
      res_q[0] <= residue_i;
    end
  end

  for (genvar s = 1; s <= RED_STAGES; s++) begin : g_red
    residue_t rem_in;

    if (s == 1) begin : g_first
      assign rem_in = '0;
    end else begin : g_next
      assign rem_in = rem_q[s-2];
    end

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        rem_q[s-1] <= rem_step(rem_in, dvd_q[s-1][RED_BITS-1 -: RED_STEPS], modulus_i);
        res_q[s]   <= res_q[s-1];
      end
    end

    if (s < RED_STAGES) begin : g_shift
      always_ff @(posedge clk_i) begin
        if (adv_i) begin
          dvd_q[s] <= dvd_q[s-1] << RED_STEPS;
        end
      end
    end
  end

  assign crt_o     = rem_q[RED_STAGES-1];
  assign residue_o = res_q[RED_STAGES];

endmodule

>>> rtl/core/rnsr_recon.sv
`timescale 1ns / 1ps

module rnsr_recon import rnsr_pkg::*; (
  input  logic     clk_i,
  input  logic     adv_i,
  input  cfg_t     cfg_i,
  input  residue_t t_a_i,
  input  residue_t t_b_i,
  input  residue_t residue_a_i,
  input  residue_t residue_b_i,
  output res_t     result_o
);

  // Q and 3Q/4 follow the moduli; the user must move config only while the pipe is empty (not enforced)
  logic [PROD_BITS-1:0]   big_q_q;
  logic [PROD_BITS-1:0]   three_q_q;
  logic [PROD_BITS+1:0]   triple;

  assign triple = {2'b00, big_q_q} + {1'b0, big_q_q, 1'b0};

  always_ff @(posedge clk_i) begin
    big_q_q   <= PROD_BITS'(cfg_i.modulus_a) * PROD_BITS'(cfg_i.modulus_b);
    three_q_q <= triple[PROD_BITS+1:2];
  end

  // stage 0: cross products, rounding sums
  logic [PROD_BITS-1:0]    ma_q, mb_q;
  logic [RESIDUE_BITS:0]   sa_q, sb_q;
  residue_t                ra0_q, rb0_q;

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      ma_q  <= PROD_BITS'(t_a_i) * PROD_BITS'(cfg_i.modulus_b);
      mb_q  <= PROD_BITS'(t_b_i) * PROD_BITS'(cfg_i.modulus_a);
      sa_q  <= {1'b0, residue_a_i} + {1'b0, cfg_i.half_residue_a};
      sb_q  <= {1'b0, residue_b_i} + {1'b0, cfg_i.half_residue_b};
      ra0_q <= residue_a_i;
      rb0_q <= residue_b_i;
    end
  end

  // stage 1: rebuild x, fold the sums once
  logic [SUM_BITS-1:0]   x_q;
  logic [RESIDUE_BITS:0] da, db;
  residue_t              fa1_q, fb1_q, ra1_q, rb1_q;

  assign da = sa_q - {1'b0, cfg_i.modulus_a};
  assign db = sb_q - {1'b0, cfg_i.modulus_b};

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      x_q   <= SUM_BITS'(ma_q) + SUM_BITS'(mb_q);
      fa1_q <= (sa_q >= {1'b0, cfg_i.modulus_a}) ? da[RESIDUE_BITS-1:0]
                                                 : sa_q[RESIDUE_BITS-1:0];
      fb1_q <= (sb_q >= {1'b0, cfg_i.modulus_b}) ? db[RESIDUE_BITS-1:0]
                                                 : sb_q[RESIDUE_BITS-1:0];
      ra1_q <= ra0_q;
      rb1_q <= rb0_q;
    end
  end

  // stage 2: x stays below 2Q, so one subtraction reduces it; x equal to Q stays as it is
  logic [SUM_BITS-1:0] xr_q;
  residue_t            fa2_q, fb2_q, ra2_q, rb2_q;

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      xr_q  <= (x_q > SUM_BITS'(big_q_q)) ? x_q - SUM_BITS'(big_q_q) : x_q;
      fa2_q <= fa1_q;
      fb2_q <= fb1_q;
      ra2_q <= ra1_q;
      rb2_q <= rb1_q;
    end
  end

  // stage 3: window test and final select
  logic nonzero;
  logic adj;
  res_t result_q;

  assign nonzero = (cfg_i.modulus_a != '0) && (cfg_i.modulus_b != '0);
  assign adj     = nonzero && (xr_q > SUM_BITS'(big_q_q >> 2))
                           && (xr_q <= SUM_BITS'(three_q_q));

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      result_q.rounded_a <= adj ? fa2_q : ra2_q;
      result_q.rounded_b <= adj ? fb2_q : rb2_q;
      result_q.adjusted  <= adj;
    end
  end

  assign result_o = result_q;

endmodule

>>> rtl/core/rnsr_out_buf.sv
`timescale 1ns / 1ps

module rnsr_out_buf import rnsr_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  res_t push_data_i,
  output logic full_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  output res_t out_data_o
);

  buf_state_e state_q, state_d;
  res_t       head_q, head_d;
  res_t       spare_q, spare_d;
  logic       pop;

  assign pop = (state_q != BUF_EMPTY) && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BUF_EMPTY;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    head_q  <= head_d;
    spare_q <= spare_d;
  end

  always_comb begin
    state_d = state_q;
    head_d  = head_q;
    spare_d = spare_q;
    case (state_q)
      BUF_EMPTY: begin
        if (push_i) begin
          head_d  = push_data_i;
          state_d = BUF_ONE;
        end
      end
      BUF_ONE: begin
        if (push_i && pop) begin
          head_d = push_data_i;
        end else if (push_i) begin
          spare_d = push_data_i;
          state_d = BUF_FULL;
        end else if (pop) begin
          state_d = BUF_EMPTY;
        end
      end
      BUF_FULL: begin
        // no push here: the pipe is held while full
        if (pop) begin
          head_d  = spare_q;
          state_d = BUF_ONE;
        end
      end
      default: begin
        state_d = BUF_EMPTY;
      end
    endcase
  end

  assign full_o      = (state_q == BUF_FULL);
  assign out_valid_o = (state_q != BUF_EMPTY);
  assign out_data_o  = head_q;

endmodule

>>> rtl/core/rns_two_limb_half_rounding.sv
`timescale 1ns / 1ps

// Two-modulus CRT reconstruction with half-modulus rounding. Each beat carries
// one coefficient as residues modulo q0 and q1; the block forms t0, t1 with the
// CRT inverses, rebuilds x = t0*q1 + t1*q0, folds it once by Q = q0*q1 and, when
// Q/4 < x <= 3Q/4, adds the programmed half residues (one conditional subtract
// each) and raises adjusted. A zero modulus passes the residues through. One
// beat is taken every cycle while the output buffer is not full. The pipeline
// is made up of the remainder units, which reduce each 62-bit product by its
// modulus four bits per stage over 16 stages, plus one multiply stage, four
// reconstruction stages and the output buffer register. A two-entry output
// buffer lets input continue while a result waits.
// Write the configuration registers only while no results are outstanding.

module rns_two_limb_half_rounding import rnsr_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0] cfg_idx_i,
  input  residue_t                cfg_wdata_i,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  residue_t                residue_a_i,
  input  residue_t                residue_b_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output residue_t                rounded_a_o,
  output residue_t                rounded_b_o,
  output logic                    adjusted_o
);

  cfg_t cfg_q, cfg_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.modulus_a      <= MODULUS_A_RST;
      cfg_q.modulus_b      <= MODULUS_B_RST;
      cfg_q.crt_inverse_a  <= '0;
      cfg_q.crt_inverse_b  <= '0;
      cfg_q.half_residue_a <= '0;
      cfg_q.half_residue_b <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_MODULUS_A:      cfg_d.modulus_a      = cfg_wdata_i;
        CFG_MODULUS_B:      cfg_d.modulus_b      = cfg_wdata_i;
        CFG_CRT_INVERSE_A:  cfg_d.crt_inverse_a  = cfg_wdata_i;
        CFG_CRT_INVERSE_B:  cfg_d.crt_inverse_b  = cfg_wdata_i;
        CFG_HALF_RESIDUE_A: cfg_d.half_residue_a = cfg_wdata_i;
        CFG_HALF_RESIDUE_B: cfg_d.half_residue_b = cfg_wdata_i;
        default: begin
          // drop writes to unused indexes
        end
      endcase
    end
  end

  // whole pipe advances together; hold it only while the output buffer is full
  logic                   adv;
  logic                   buf_full;
  logic [PIPE_STAGES-1:0] vld_q, vld_d;

  assign adv        = !buf_full;
  assign in_ready_o = adv;
  assign vld_d      = adv ? {vld_q[PIPE_STAGES-2:0], in_valid_i} : vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  residue_t ra_lane, rb_lane, t_a, t_b;
  res_t     pipe_res, out_res;

  rnsr_lane u_lane_a (
    .clk_i     (clk_i),
    .adv_i     (adv),
    .residue_i (residue_a_i),
    .inverse_i (cfg_q.crt_inverse_a),
    .modulus_i (cfg_q.modulus_a),
    .residue_o (ra_lane),
    .crt_o     (t_a)
  );

  rnsr_lane u_lane_b (
    .clk_i     (clk_i),
    .adv_i     (adv),
    .residue_i (residue_b_i),
    .inverse_i (cfg_q.crt_inverse_b),
    .modulus_i (cfg_q.modulus_b),
    .residue_o (rb_lane),
    .crt_o     (t_b)
  );

  rnsr_recon u_recon (
    .clk_i       (clk_i),
    .adv_i       (adv),
    .cfg_i       (cfg_q),
    .t_a_i       (t_a),
    .t_b_i       (t_b),
    .residue_a_i (ra_lane),
    .residue_b_i (rb_lane),
    .result_o    (pipe_res)
  );

  rnsr_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (adv && vld_q[PIPE_STAGES-1]),
    .push_data_i (pipe_res),
    .full_o      (buf_full),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_res)
  );

  assign rounded_a_o = out_res.rounded_a;
  assign rounded_b_o = out_res.rounded_b;
  assign adjusted_o  = out_res.adjusted;

endmodule

>>> tb/sv/tb_rns_two_limb_half_rounding.sv
`timescale 1ns / 1ps

module tb_rns_two_limb_half_rounding import rnsr_pkg::*; ();

  localparam int LIMIT_CYCLES   = 200000;
  localparam int RANDOM_PHASES  = 12;
  localparam int PHASE_ITEMS    = 100;
  localparam int DRAIN_CYCLES   = 30;
  localparam logic [CFG_IDX_BITS-1:0] CFG_UNUSED_LO = 3'd6;
  localparam logic [CFG_IDX_BITS-1:0] CFG_UNUSED_HI = 3'd7;

  typedef struct packed {
    logic [2:0] cfg_sel;
    residue_t   residue_a;
    residue_t   residue_b;
    logic       typed;
    res_t       want;
  } dir_row_t;

  logic                    clk_i;
  logic                    rst_ni;
  logic                    cfg_we_i;
  logic [CFG_IDX_BITS-1:0] cfg_idx_i;
  residue_t                cfg_wdata_i;
  logic                    in_valid_i;
  logic                    in_ready_o;
  residue_t                residue_a_i;
  residue_t                residue_b_i;
  logic                    out_valid_o;
  logic                    out_ready_i;
  residue_t                rounded_a_o;
  residue_t                rounded_b_o;
  logic                    adjusted_o;

  cfg_t     lane_cfg;
  cfg_t     dir_cfgs [7];
  dir_row_t dir_rows [$];
  res_t     pending_rounding_q [$];
  res_t     oldest_rounding;
  int       error_count;
  int       results_seen;
  int       send_idle_pct;
  int       recv_stall_pct;
  int       cycle_count;

  rns_two_limb_half_rounding dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .residue_a_i (residue_a_i),
    .residue_b_i (residue_b_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .rounded_a_o (rounded_a_o),
    .rounded_b_o (rounded_b_o),
    .adjusted_o  (adjusted_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    for (cycle_count = 0; cycle_count < LIMIT_CYCLES; cycle_count++) @(posedge clk_i);
    $display("FAIL");
    $finish;
  end

  task automatic report_error(input string msg);
    $display("ERROR at result %0d: %s", results_seen, msg);
    error_count++;
  endtask

  function automatic logic [63:0] gcd_u64(logic [63:0] a, logic [63:0] b);
    logic [63:0] t;
    while (b != 0) begin
      t = a % b;
      a = b;
      b = t;
    end
    return a;
  endfunction

  // extended Euclid; m == 1 gives 0
  function automatic logic [63:0] mod_inverse(logic [63:0] a, logic [63:0] m);
    longint t, nt, r, nr, quo, tmp;
    t  = 0;
    nt = 1;
    r  = longint'(m);
    nr = longint'(a % m);
    while (nr != 0) begin
      quo = r / nr;
      tmp = t - quo * nt;
      t   = nt;
      nt  = tmp;
      tmp = r - quo * nr;
      r   = nr;
      nr  = tmp;
    end
    if (t < 0) t = t + longint'(m);
    return 64'(t);
  endfunction

  function automatic cfg_t build_crt_cfg(logic [63:0] q0, logic [63:0] q1);
    cfg_t        c;
    logic [63:0] half;
    half             = (q0 * q1) / 2;
    c.modulus_a      = residue_t'(q0);
    c.modulus_b      = residue_t'(q1);
    c.crt_inverse_a  = residue_t'(mod_inverse(q1, q0));
    c.crt_inverse_b  = residue_t'(mod_inverse(q0, q1));
    c.half_residue_a = residue_t'(half % q0);
    c.half_residue_b = residue_t'(half % q1);
    return c;
  endfunction

  function automatic res_t predict_rounding(residue_t ra, residue_t rb);
    logic [63:0] q0, q1, big_q, t0, t1, x, quarter, three_quarter, sum;
    res_t        r;
    r.rounded_a = ra;
    r.rounded_b = rb;
    r.adjusted  = 1'b0;
    q0 = 64'(lane_cfg.modulus_a);
    q1 = 64'(lane_cfg.modulus_b);
    if (q0 != 0 && q1 != 0) begin
      big_q = q0 * q1;
      t0 = ((64'(ra) % q0) * (64'(lane_cfg.crt_inverse_a) % q0)) % q0;
      t1 = ((64'(rb) % q1) * (64'(lane_cfg.crt_inverse_b) % q1)) % q1;
      x  = t0 * q1 + t1 * q0;
      quarter       = big_q / 4;
      three_quarter = (3 * big_q) / 4;
      // fold once; x equal to Q stays as it is
      if (x > big_q) x = x % big_q;
      if (x > quarter && x <= three_quarter) begin
        r.adjusted = 1'b1;
        sum = 64'(ra) + 64'(lane_cfg.half_residue_a);
        if (sum >= q0) sum = sum - q0;
        r.rounded_a = residue_t'(sum);
        sum = 64'(rb) + 64'(lane_cfg.half_residue_b);
        if (sum >= q1) sum = sum - q1;
        r.rounded_b = residue_t'(sum);
      end
    end
    return r;
  endfunction

  function automatic dir_row_t dir_row(int sel, residue_t ra, residue_t rb, logic typed,
                                       residue_t wa, residue_t wb, logic wadj);
    dir_row_t d;
    d.cfg_sel        = 3'(sel);
    d.residue_a      = ra;
    d.residue_b      = rb;
    d.typed          = typed;
    d.want.rounded_a = wa;
    d.want.rounded_b = wb;
    d.want.adjusted  = wadj;
    return d;
  endfunction

  task automatic add_dir_row(input dir_row_t d);
    dir_rows = {dir_rows, d};
  endtask

  task automatic cfg_write(input logic [CFG_IDX_BITS-1:0] idx, input residue_t data);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
  endtask

  task automatic apply_cfg(input cfg_t c);
    // unused indices first: they must not disturb anything
    cfg_write(CFG_UNUSED_LO, residue_t'($urandom));
    cfg_write(CFG_UNUSED_HI, residue_t'($urandom));
    cfg_write(CFG_MODULUS_A, c.modulus_a);
    cfg_write(CFG_MODULUS_B, c.modulus_b);
    cfg_write(CFG_CRT_INVERSE_A, c.crt_inverse_a);
    cfg_write(CFG_CRT_INVERSE_B, c.crt_inverse_b);
    cfg_write(CFG_HALF_RESIDUE_A, c.half_residue_a);
    cfg_write(CFG_HALF_RESIDUE_B, c.half_residue_b);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    lane_cfg = c;
  endtask

  task automatic drain_results();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_rounding_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic send_coeff(input residue_t ra, input residue_t rb, input logic typed,
                            input res_t want);
    @(negedge clk_i);
    while ($urandom_range(99, 0) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    residue_a_i <= ra;
    residue_b_i <= rb;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    pending_rounding_q = {pending_rounding_q, typed ? want : predict_rounding(ra, rb)};
  endtask

  always @(negedge clk_i) out_ready_i <= ($urandom_range(99, 0) >= recv_stall_pct);

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_rounding_q.size() == 0) begin
        report_error("result beat with nothing expected");
      end else begin
        oldest_rounding = pending_rounding_q.pop_front();
        if (rounded_a_o !== oldest_rounding.rounded_a)
          report_error($sformatf("rounded_a got %0d want %0d",
                                 rounded_a_o, oldest_rounding.rounded_a));
        if (rounded_b_o !== oldest_rounding.rounded_b)
          report_error($sformatf("rounded_b got %0d want %0d",
                                 rounded_b_o, oldest_rounding.rounded_b));
        if (adjusted_o !== oldest_rounding.adjusted)
          report_error($sformatf("adjusted got %0b want %0b",
                                 adjusted_o, oldest_rounding.adjusted));
      end
      results_seen++;
    end
  end

  initial begin
    cfg_t        c;
    residue_t    ra, rb;
    logic [63:0] qa, qb, big_q, v;
    int          cur_sel, kind, pick;

    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_idx_i      = CFG_MODULUS_A;
    cfg_wdata_i    = '0;
    in_valid_i     = 1'b0;
    residue_a_i    = '0;
    residue_b_i    = '0;
    error_count    = 0;
    results_seen   = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;

    // fields: modulus a/b, crt inverse a/b, half residue a/b
    dir_cfgs[0] = '{MODULUS_A_RST, MODULUS_B_RST, 31'd0, 31'd0, 31'd0, 31'd0};
    dir_cfgs[1] = '{31'd0, MODULUS_B_RST, 31'd0, 31'd0, 31'd0, 31'd0};
    dir_cfgs[2] = '{31'd5, 31'd0, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF};
    dir_cfgs[3] = build_crt_cfg(64'h7FFF_FFFF, 64'h7FFF_FFED);
    dir_cfgs[4] = '{31'd1000, 31'd1000, 31'd1, 31'd1, 31'd500, 31'd500};
    dir_cfgs[5] = '{31'd1000003, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF,
                    31'h7FFF_FFFF, 31'h7FFF_FFFF};
    dir_cfgs[6] = build_crt_cfg(64'd2, 64'd3);

    // reset values: inverses are zero, so everything passes through
    add_dir_row(dir_row(0, 31'd0, 31'd0, 1, 31'd0, 31'd0, 0));
    add_dir_row(dir_row(0, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 1,
                        31'h7FFF_FFFF, 31'h7FFF_FFFF, 0));
    add_dir_row(dir_row(0, 31'h7FFF_FFFF, 31'd0, 1, 31'h7FFF_FFFF, 31'd0, 0));
    add_dir_row(dir_row(0, 31'd0, 31'h5555_5555, 1, 31'd0, 31'h5555_5555, 0));
    // zero modulus on either limb: pass through
    add_dir_row(dir_row(1, 31'd1234, 31'd5678, 1, 31'd1234, 31'd5678, 0));
    add_dir_row(dir_row(1, 31'h7FFF_FFFF, 31'h7FFF_FFFE, 1,
                        31'h7FFF_FFFF, 31'h7FFF_FFFE, 0));
    add_dir_row(dir_row(2, 31'd4, 31'd0, 1, 31'd4, 31'd0, 0));
    add_dir_row(dir_row(2, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 1,
                        31'h7FFF_FFFF, 31'h7FFF_FFFF, 0));
    // large coprime pair: the reset moduli
    add_dir_row(dir_row(3, 31'd0, 31'd0, 0, 31'd0, 31'd0, 0));
    add_dir_row(dir_row(3, 31'h7FFF_FFFE, 31'h7FFF_FFEC, 0, 31'd0, 31'd0, 0));
    add_dir_row(dir_row(3, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 0, 31'd0, 31'd0, 0));
    add_dir_row(dir_row(3, 31'd1, 31'd0, 0, 31'd0, 31'd0, 0));
    // equal moduli: x equal to Q, window edges, wrap in the half addition
    add_dir_row(dir_row(4, 31'd300, 31'd700, 0, 31'd0, 31'd0, 0));
    add_dir_row(dir_row(4, 31'd250, 31'd0, 0, 31'd0, 31'd0, 0));
    add_dir_row(dir_row(4, 31'd251, 31'd0, 0, 31'd0, 31'd0, 0));
    add_dir_row(dir_row(4, 31'd750, 31'd0, 0, 31'd0, 31'd0, 0));
    add_dir_row(dir_row(4, 31'd751, 31'd0, 0, 31'd0, 31'd0, 0));
    add_dir_row(dir_row(4, 31'd600, 31'd150, 0, 31'd0, 31'd0, 0));
    // unreduced inverses and half residues
    add_dir_row(dir_row(5, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 0, 31'd0, 31'd0, 0));
    add_dir_row(dir_row(5, 31'd999999, 31'd5, 0, 31'd0, 31'd0, 0));
    add_dir_row(dir_row(5, 31'd0, 31'h4000_0000, 0, 31'd0, 31'd0, 0));
    // small coprime pair: moduli 2 and 3
    add_dir_row(dir_row(6, 31'd0, 31'd0, 0, 31'd0, 31'd0, 0));
    add_dir_row(dir_row(6, 31'd1, 31'd0, 0, 31'd0, 31'd0, 0));
    add_dir_row(dir_row(6, 31'd0, 31'd2, 0, 31'd0, 31'd0, 0));
    add_dir_row(dir_row(6, 31'd1, 31'd2, 0, 31'd0, 31'd0, 0));

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    lane_cfg = dir_cfgs[0];
    cur_sel  = 0;
    foreach (dir_rows[i]) begin
      if (int'(dir_rows[i].cfg_sel) != cur_sel) begin
        drain_results();
        cur_sel = int'(dir_rows[i].cfg_sel);
        apply_cfg(dir_cfgs[cur_sel]);
      end
      send_coeff(dir_rows[i].residue_a, dir_rows[i].residue_b, dir_rows[i].typed,
                 dir_rows[i].want);
    end

    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      drain_results();
      kind = $urandom_range(9, 0);
      if (kind <= 8) begin
        do begin
          if (kind <= 4) begin
            qa = $urandom_range(32'h7FFF_FFFF, 2);
            qb = $urandom_range(32'h7FFF_FFFF, 2);
          end else if (kind <= 6) begin
            qa = $urandom_range(64, 1);
            qb = $urandom_range(64, 1);
          end else if (kind == 7) begin
            qa = $urandom_range(32'h7FFF_FFFF, 2);
            qb = $urandom_range(1000, 2);
          end else begin
            qa = 64'h7FFF_FFFF;
            qb = $urandom_range(32'h7FFF_FFFF, 32'h7FFF_0000);
          end
        end while (gcd_u64(qa, qb) != 1);
        c = build_crt_cfg(qa, qb);
      end else begin
        // arbitrary register contents, zero modulus now and then
        c.modulus_a      = residue_t'($urandom);
        c.modulus_b      = residue_t'($urandom);
        c.crt_inverse_a  = residue_t'($urandom);
        c.crt_inverse_b  = residue_t'($urandom);
        c.half_residue_a = residue_t'($urandom);
        c.half_residue_b = residue_t'($urandom);
        if ($urandom_range(2, 0) == 0) c.modulus_a = '0;
        if ($urandom_range(2, 0) == 0) c.modulus_b = '0;
      end
      apply_cfg(c);

      case (phase % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 66; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 66; end
        default: begin send_idle_pct = 7; recv_stall_pct = 7; end
      endcase

      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // hold the sender once until the pipe is empty
        if (phase == 5 && n == PHASE_ITEMS / 2) drain_results();
        qa   = 64'(lane_cfg.modulus_a);
        qb   = 64'(lane_cfg.modulus_b);
        pick = $urandom_range(99, 0);
        if (pick < 60 && qa != 0 && qb != 0) begin
          // pick a coefficient value near the window edges, near 0 or Q, or at random
          big_q = qa * qb;
          case ($urandom_range(4, 0))
            0:       v = big_q / 4;
            1:       v = (3 * big_q) / 4;
            2:       v = 0;
            3:       v = big_q - 1;
            default: v = {$urandom, $urandom} % big_q;
          endcase
          v  = (v + big_q + 64'($urandom_range(4, 0)) - 2) % big_q;
          ra = residue_t'(v % qa);
          rb = residue_t'(v % qb);
        end else if (pick < 85) begin
          ra = (qa != 0) ? residue_t'($urandom % qa) : residue_t'($urandom);
          rb = (qb != 0) ? residue_t'($urandom % qb) : residue_t'($urandom);
        end else begin
          ra = residue_t'($urandom);
          rb = residue_t'($urandom);
        end
        send_coeff(ra, rb, 1'b0, '0);
      end
    end

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (pending_rounding_q.size() != 0)
      report_error($sformatf("%0d results never arrived", pending_rounding_q.size()));
    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/core/rnsr_pkg.sv
rtl/core/rnsr_lane.sv
rtl/core/rnsr_recon.sv
rtl/core/rnsr_out_buf.sv
rtl/core/rns_two_limb_half_rounding.sv
tb/sv/tb_rns_two_limb_half_rounding.sv
